/* rtl/core/scfr_pkg.sv */
// scfr_pkg: shared types and constants for the serial command frame receiver
// beat structs, phase and event codes, command characters and size limits
// no dependencies
`default_nettype none

package scfr_pkg;

  // buffer and register widths
  localparam int unsigned BufLimit  = 4096;
  localparam int unsigned PosW      = 13;
  localparam int unsigned LenW      = 16;
  localparam int unsigned TickW     = 16;
  localparam int unsigned ErrW      = 16;

  // command characters
  localparam logic [7:0] CMD_R = 8'h52;
  localparam logic [7:0] CMD_F = 8'h46;
  localparam logic [7:0] CMD_W = 8'h57;
  localparam logic [7:0] CMD_B = 8'h42;
  localparam logic [7:0] CMD_S = 8'h53;
  localparam logic [7:0] CMD_M = 8'h4D;
  localparam logic [7:0] CMD_L = 8'h4C;

  // input item kinds
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // register map indexes
  localparam logic REG_MAX_LENGTH    = 1'b0;
  localparam logic REG_TIMEOUT_TICKS = 1'b1;

  // reset values of the registers
  localparam logic [PosW-1:0]  MAX_LENGTH_RST    = 13'd256;
  localparam logic [TickW-1:0] TIMEOUT_TICKS_RST = 16'd10;

  // result event codes
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_STORED  = 3'd1,
    EV_GOOD    = 3'd2,
    EV_BAD     = 3'd3,
    EV_LENGTH  = 3'd4,
    EV_TIMEOUT = 3'd5
  } event_t;

  // frame parser phase, one-hot
  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_ADDR_HI = 7'b0000010,
    PH_ADDR_LO = 7'b0000100,
    PH_LEN_HI  = 7'b0001000,
    PH_LEN     = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_CHECK   = 7'b1000000
  } phase_t;

  // input beat
  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } item_t;

  // result beat
  typedef struct packed {
    logic [2:0]      event_res;
    logic [7:0]      byte_value;
    logic [PosW-1:0] byte_index;
    logic [7:0]      command;
    logic [LenW-1:0] frame_length;
    logic [ErrW-1:0] error_count;
  } result_t;

  function automatic logic is_command(input logic [7:0] c);
    return (c == CMD_R) || (c == CMD_F) || (c == CMD_W) || (c == CMD_B) ||
           (c == CMD_S) || (c == CMD_M) || (c == CMD_L);
  endfunction

  function automatic logic is_payload_command(input logic [7:0] c);
    return (c == CMD_B) || (c == CMD_M) || (c == CMD_L);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/serial_command_frame_receiver.sv */
// serial_command_frame_receiver: frame parser, checksum and timeout logic
// depends on scfr_pkg for beat structs, phase and event codes
`default_nettype none

// Takes one beat per clock while item_ready is high: a received byte or a timer
// tick, and returns exactly one result beat for each. A frame is a command
// byte (R F W B S M L), two address bytes, a one-byte length (two bytes, high
// first, for M and L), a payload of that length for B, M and L, and an 8-bit
// additive checksum. Every stored byte comes out with its buffer index; the
// checksum byte gives a good or bad verdict. The parser state is a single
// register set updated in one pass per beat, so it sustains one item per
// cycle while results drain. The result side holds a result register plus one
// skid entry, so one more item is taken while a result waits; item_ready drops
// only when both are full. Registers max_length (addr 0) and timeout_ticks
// (addr 4) sit on the APB port and should be written while the block is idle.
module serial_command_frame_receiver (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // input channel
  input  wire logic                    item_valid,
  output logic                         item_ready,
  input  wire scfr_pkg::item_t         item,
  // result channel
  output logic                         result_valid,
  input  wire logic                    result_ready,
  output scfr_pkg::result_t            result,
  // register port
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [2:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import scfr_pkg::*;

  // configuration
  logic [PosW-1:0]  max_length;
  logic [TickW-1:0] timeout_ticks;

  // parser state
  phase_t           phase, phase_next;
  logic [PosW-1:0]  write_position, write_position_next;
  logic [PosW-1:0]  payload_remaining, payload_remaining_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [LenW-1:0]  length_field, length_field_next;
  logic [7:0]       current_command, current_command_next;
  logic [ErrW-1:0]  error_tally, error_tally_next;
  logic [TickW-1:0] idle_ticks, idle_ticks_next;

  // output register and skid entry
  result_t          skid;
  logic             skid_valid;
  result_t          res_new;

  // step helpers
  logic             accept;
  logic             cfg_write;
  logic [PosW-1:0]  len_limit;
  logic [TickW-1:0] tick_limit;
  logic [TickW-1:0] ticks_inc;
  logic [LenW-1:0]  len_hi_value;
  logic [LenW-1:0]  len_sum;
  logic [PosW-1:0]  rem_dec;
  logic             do_store;
  logic [PosW-1:0]  store_base;
  logic [7:0]       sum_base;
  event_t           ev;
  logic [7:0]       b;

  assign accept    = item_valid && item_ready;
  assign item_ready = !skid_valid;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign b         = item.rx_byte;

  // register readback
  always_comb begin
    case (paddr[2])
      REG_MAX_LENGTH:    prdata = {{(32-PosW){1'b0}}, max_length};
      REG_TIMEOUT_TICKS: prdata = {{(32-TickW){1'b0}}, timeout_ticks};
      default:           prdata = '0;
    endcase
  end

  // effective limits: length capped at buffer size, timeout of zero acts as one
  assign len_limit    = (max_length > PosW'(BufLimit)) ? PosW'(BufLimit) : max_length;
  assign tick_limit   = (timeout_ticks == '0) ? TickW'(1) : timeout_ticks;
  assign ticks_inc    = (idle_ticks == '1) ? idle_ticks : idle_ticks + TickW'(1);
  assign len_hi_value = {b, 8'h00};
  assign len_sum      = length_field + {8'h00, b};
  assign rem_dec      = payload_remaining - PosW'(1);

  // one pass of the frame parser
  always_comb begin
    phase_next             = phase;
    write_position_next    = write_position;
    payload_remaining_next = payload_remaining;
    running_sum_next       = running_sum;
    length_field_next      = length_field;
    current_command_next   = current_command;
    error_tally_next       = error_tally;
    idle_ticks_next        = idle_ticks;
    ev                     = EV_NONE;
    do_store               = 1'b0;
    store_base             = write_position;
    sum_base               = running_sum;
    res_new                = '0;

    if (item.func == FUNC_TICK) begin
      // tick: count toward timeout unless idle
      if (phase != PH_IDLE) begin
        idle_ticks_next = ticks_inc;
        if (ticks_inc >= tick_limit) begin
          error_tally_next = error_tally + ErrW'(1);
          phase_next       = PH_IDLE;
          idle_ticks_next  = '0;
          ev               = EV_TIMEOUT;
        end
      end
    end else begin
      idle_ticks_next = '0;
      case (phase)
        PH_IDLE: begin
          if (is_command(b)) begin
            current_command_next = b;
            store_base           = '0;
            sum_base             = '0;
            do_store             = 1'b1;
            phase_next           = PH_ADDR_HI;
          end
        end
        PH_ADDR_HI: begin
          do_store   = 1'b1;
          phase_next = PH_ADDR_LO;
        end
        PH_ADDR_LO: begin
          do_store          = 1'b1;
          length_field_next = '0;
          phase_next = ((current_command == CMD_M) || (current_command == CMD_L)) ?
                       PH_LEN_HI : PH_LEN;
        end
        PH_LEN_HI: begin
          length_field_next = len_hi_value;
          if (len_hi_value > {{(LenW-PosW){1'b0}}, len_limit}) begin
            running_sum_next    = running_sum + b;
            error_tally_next    = error_tally + ErrW'(1);
            phase_next          = PH_IDLE;
            write_position_next = '0;
            ev                  = EV_LENGTH;
          end else begin
            do_store   = 1'b1;
            phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          length_field_next = len_sum;
          if (is_payload_command(current_command)) begin
            if ((len_sum == '0) || (len_sum > {{(LenW-PosW){1'b0}}, len_limit})) begin
              running_sum_next    = running_sum + b;
              error_tally_next    = error_tally + ErrW'(1);
              phase_next          = PH_IDLE;
              write_position_next = '0;
              ev                  = EV_LENGTH;
            end else begin
              do_store               = 1'b1;
              payload_remaining_next = len_sum[PosW-1:0];
              phase_next             = PH_PAYLOAD;
            end
          end else begin
            do_store   = 1'b1;
            phase_next = PH_CHECK;
          end
        end
        PH_PAYLOAD: begin
          do_store               = 1'b1;
          payload_remaining_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          ev                   = (b == running_sum) ? EV_GOOD : EV_BAD;
          res_new.frame_length = length_field;
          phase_next           = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    // store a frame byte: report it, advance position and checksum
    if (do_store) begin
      ev                  = EV_STORED;
      res_new.byte_value  = b;
      res_new.byte_index  = store_base;
      write_position_next = store_base + PosW'(1);
      running_sum_next    = sum_base + b;
    end

    res_new.event_res   = ev;
    res_new.command     = current_command_next;
    res_new.error_count = error_tally_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length    <= MAX_LENGTH_RST;
      timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_MAX_LENGTH:    max_length    <= pwdata[PosW-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  // parser state update on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      write_position    <= '0;
      payload_remaining <= '0;
      running_sum       <= '0;
      length_field      <= '0;
      current_command   <= '0;
      error_tally       <= '0;
      idle_ticks        <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      write_position    <= write_position_next;
      payload_remaining <= payload_remaining_next;
      running_sum       <= running_sum_next;
      length_field      <= length_field_next;
      current_command   <= current_command_next;
      error_tally       <= error_tally_next;
      idle_ticks        <= idle_ticks_next;
    end
  end

  // result register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || result_ready) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // result payloads
  always_ff @(posedge clk) begin
    if (!result_valid || result_ready) begin
      if (skid_valid) begin
        result <= skid;
      end else begin
        result <= res_new;
      end
    end else if (accept) begin
      skid <= res_new;
    end
  end

endmodule

`default_nettype wire
